FILE: sv/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
`default_nettype none
package mhpq_pkg;

  localparam int unsigned DataW = 32;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    vld;
    logic                    ge;    // holds a value >= the one being inserted
    logic signed [DataW-1:0] data;
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    shift_in;   // insert: open a slot, shift right
    logic                    shift_out;  // remove: shift left
    logic signed [DataW-1:0] value;
  } ctrl_t;

endpackage
`default_nettype wire

FILE: sv/mhpq_ifs.sv
// Valid/ready channel interfaces for the request and result words.
`default_nettype none
interface mhpq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface mhpq_out_if #(
  parameter int unsigned COUNT_W = 7
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic signed [31:0] top_value;
  logic [COUNT_W-1:0] count;

  modport source (output valid, status, removed_value, top_value, count, input ready);
  modport sink   (input valid, status, removed_value, top_value, count, output ready);
endinterface
`default_nettype wire

FILE: sv/mhpq_cell.sv
// One slot of the sorted shift chain: holds one value and its valid bit.
`default_nettype none
module mhpq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mhpq_pkg::ctrl_t ctrl_i,
  input  mhpq_pkg::link_t left_i,
  input  mhpq_pkg::link_t right_i,
  output mhpq_pkg::link_t link_o
);
  import mhpq_pkg::*;

  logic                    vld_q;
  logic signed [DataW-1:0] data_q;
  logic                    ge;

  assign ge = vld_q && (data_q >= ctrl_i.value);

  assign link_o.vld  = vld_q;
  assign link_o.ge   = ge;
  assign link_o.data = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.shift_in && !ge) begin
      vld_q <= left_i.ge ? 1'b1 : left_i.vld;
    end else if (ctrl_i.shift_out) begin
      vld_q <= right_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_in && !ge) begin
      data_q <= left_i.ge ? ctrl_i.value : left_i.data;
    end else if (ctrl_i.shift_out) begin
      data_q <= right_i.data;
    end
  end

endmodule
`default_nettype wire

FILE: sv/max_heap_priority_queue_top.sv
// Top level of the max priority queue: cell chain, entry count and result register.
`default_nettype none
// Priority queue of up to CAPACITY signed 32-bit values. Each request word
// either inserts a value or removes the maximum, and yields one result word
// with a status, the removed value, the new maximum and the entry count.
// Storage is a chain of CAPACITY identical cells kept sorted, largest first:
// an insert makes every cell compare its value with the new one and the
// chain opens a slot by shifting right from there; a remove shifts the whole
// chain left by one. Either way the chain shifts at the clock edge that
// accepts the request, and its result appears in the output register the cycle
// after acceptance. A new request is taken whenever the output register is
// empty or being drained, giving one request per cycle when the sink keeps up.
// An insert into a full queue is dropped with status full; a remove from an
// empty queue leaves the state alone with status empty. The maximum reported
// on an empty queue is 0. No clearing pass is needed after reset: the cells'
// valid bits clear at once.
module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mhpq_in_if.sink     in_i,
  mhpq_out_if.source  out_o
);
  import mhpq_pkg::*;

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  // chain of cells
  link_t lnk [CAPACITY];
  ctrl_t ctrl;

  // head sees a virtual neighbor that always lets the new value in;
  // tail sees an empty neighbor so a remove clears the last slot
  localparam link_t HeadLink = '{vld: 1'b1, ge: 1'b1, data: '0};
  localparam link_t TailLink = '{vld: 1'b0, ge: 1'b0, data: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t left_l;
    link_t right_l;
    if (i == 0) begin : g_head
      assign left_l = HeadLink;
    end else begin : g_mid_l
      assign left_l = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = TailLink;
    end else begin : g_mid_r
      assign right_l = lnk[i+1];
    end
    mhpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (lnk[i])
    );
  end

  // request decode
  logic              accept;
  logic              is_ins;
  logic              full;
  logic              empty;
  logic [CountW-1:0] count_q, count_d;

  assign accept = in_i.valid && in_i.ready;
  assign is_ins = (in_i.action == ACT_INSERT);
  assign full   = (count_q == CountW'(CAPACITY));
  assign empty  = (count_q == '0);

  assign ctrl.shift_in  = accept && is_ins && !full;
  assign ctrl.shift_out = accept && !is_ins && !empty;
  assign ctrl.value     = in_i.value;

  // result of this request, computed from the chain before it shifts
  logic [1:0]              status_d;
  logic signed [DataW-1:0] removed_d;
  logic signed [DataW-1:0] top_d;

  always_comb begin
    count_d   = count_q;
    status_d  = STATUS_DONE;
    removed_d = '0;
    top_d     = lnk[0].data;
    if (is_ins) begin
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        count_d = count_q + CountW'(1);
        if (empty || (in_i.value > lnk[0].data)) top_d = in_i.value;
      end
    end else begin
      if (empty) begin
        status_d = STATUS_EMPTY;
        top_d    = '0;
      end else begin
        count_d   = count_q - CountW'(1);
        removed_d = lnk[0].data;
        // second slot exists only with two or more entries
        top_d     = (count_q > CountW'(1)) ? lnk[1].data : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // output register
  logic                    out_vld_q;
  logic [1:0]              status_q;
  logic signed [DataW-1:0] removed_q;
  logic signed [DataW-1:0] top_q;
  logic [CountW-1:0]       out_count_q;

  assign in_i.ready = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      out_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      removed_q   <= removed_d;
      top_q       <= top_d;
      out_count_q <= count_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = status_q;
  assign out_o.removed_value = removed_q;
  assign out_o.top_value     = top_q;
  assign out_o.count         = out_count_q;

  // checks
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_head_vld : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lnk[0].vld == (count_q != '0))
    else $error("head cell valid disagrees with entry count");

  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lnk[1].vld |-> (lnk[0].vld && (lnk[0].data >= lnk[1].data)))
    else $error("head pair out of order");

  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (status_q == STATUS_FULL)) |-> (out_count_q == CountW'(CAPACITY)))
    else $error("full status with room left");

  a_empty_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_count_q == '0)) |-> (top_q == '0))
    else $error("nonzero maximum reported on empty queue");

endmodule
`default_nettype wire
